/* sv/sdt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdt_pkg: shared types and constants for the sorted date table
// Operation and status codes, the default table size, and the command and
// status bundles exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package sdt_pkg;

    // Default number of table entries
    localparam int CAPACITY = 32;

    // Field widths of the stream payload
    localparam int OP_W     = 3;
    localparam int DATE_W   = 16;
    localparam int POS_W    = 6;
    localparam int PAY_W    = 16;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 6;
    localparam int REM_W    = 6;
    localparam int WORD_W   = DATE_W + PAY_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
    localparam logic [OP_W-1:0] OP_READ_INDEX = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND_DATE  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_INDEX  = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_RANGE  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_BEFORE = 3'd5;
    localparam logic [OP_W-1:0] OP_LIST_RANGE = 3'd6;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // request accepted: capture operands
        logic run;    // walk the table
        logic fin;    // deliver the closing result
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_end;   // walk is complete
        logic out_free;   // output register can take a result
    } t_dp_stat;

endpackage

/* sv/sdt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdt_ram: generic simple dual-port RAM
// One write port and one read port with registered read data; the read
// data holds while the read enable is low.
// ----------------------------------------------------------------------------
module sdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/sdt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdt_datapath: entry storage, table walk and result register
// Holds the entry RAM, the read and write pointers of the walk, the entry
// count, the pending entry and the output register. One entry is read per
// cycle unless a listed entry stalls; inserts shift up, deletes compact down.
// ----------------------------------------------------------------------------
module sdt_datapath #(
    parameter int CAPACITY = sdt_pkg::CAPACITY
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sdt_pkg::t_ctrl_cmd    i_cmd,
    output sdt_pkg::t_dp_stat     o_stat,
    input  logic [55:0]           i_s_tdata,   // date_a, date_b, position, payload
    input  logic [2:0]            i_s_tuser,   // op
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [47:0]           o_m_tdata,   // status, result_index, removed_count,
                                               // entry_date, entry_payload
    output logic                  o_m_tlast    // last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = sdt_pkg::DATE_W;
    localparam int PW = sdt_pkg::PAY_W;
    localparam int WW = sdt_pkg::WORD_W;

    // Request fields
    logic [sdt_pkg::OP_W-1:0]  w_op;
    logic [DW-1:0]             w_da;
    logic [DW-1:0]             w_db;
    logic [sdt_pkg::POS_W-1:0] w_pos;
    logic [PW-1:0]             w_pay;

    assign w_op  = i_s_tuser[2:0];
    assign w_da  = i_s_tdata[15:0];
    assign w_db  = i_s_tdata[31:16];
    assign w_pos = i_s_tdata[37:32];
    assign w_pay = i_s_tdata[53:38];

    // Operand registers
    logic [sdt_pkg::OP_W-1:0]     r_op;
    logic [DW-1:0]                r_da;
    logic [DW-1:0]                r_lo;
    logic [DW-1:0]                r_hi;
    logic [sdt_pkg::POS_W-1:0]    r_pos;
    logic [PW-1:0]                r_pay;
    logic                         r_imm;
    logic [sdt_pkg::STATUS_W-1:0] r_ist;

    // Walk state
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rd;
    logic [CW-1:0] r_wr;
    logic [CW-1:0] r_rem;
    logic [AW-1:0] r_didx;
    logic [AW-1:0] r_ridx;
    logic          r_dv;
    logic          r_hit;

    // Pending entry (found, read or listed)
    logic          r_pv;
    logic [AW-1:0] r_pidx;
    logic [DW-1:0] r_pdate;
    logic [PW-1:0] r_ppay;

    // Output register
    logic                         r_ov;
    logic [sdt_pkg::STATUS_W-1:0] r_ost;
    logic [sdt_pkg::IDX_W-1:0]    r_oidx;
    logic [sdt_pkg::REM_W-1:0]    r_orem;
    logic [DW-1:0]                r_odate;
    logic [PW-1:0]                r_opay;
    logic                         r_olast;

    // RAM ports
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [WW-1:0] w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [WW-1:0] w_q;

    // Decoded walk signals
    logic          w_is_ins;
    logic          w_is_look;
    logic          w_is_pack;
    logic          w_is_list;
    logic          w_rd_avail;
    logic [DW-1:0] w_d_date;
    logic [PW-1:0] w_d_pay;
    logic          w_in_rng;
    logic          w_eval;
    logic          w_out_free;
    logic          w_mid;
    logic          w_stall;
    logic          w_hit_now;
    logic          w_remove;
    logic          w_fin_fire;
    logic [CW-1:0] w_didx_inc;

    // Load-time operand values
    logic [DW-1:0]                n_lo;
    logic [DW-1:0]                n_hi;
    logic                         n_imm;
    logic [sdt_pkg::STATUS_W-1:0] n_ist;
    logic [CW-1:0]                n_rd;

    // Closing result values
    logic [sdt_pkg::STATUS_W-1:0] n_ost;
    logic [sdt_pkg::IDX_W-1:0]    n_oidx;
    logic [sdt_pkg::REM_W-1:0]    n_orem;
    logic [DW-1:0]                n_odate;
    logic [PW-1:0]                n_opay;

    sdt_ram #(
        .WIDTH (WW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    // Decode operation class
    assign w_is_ins  = (r_op == sdt_pkg::OP_INSERT);
    assign w_is_look = (r_op == sdt_pkg::OP_READ_INDEX) || (r_op == sdt_pkg::OP_FIND_DATE);
    assign w_is_pack = (r_op == sdt_pkg::OP_DEL_INDEX) || (r_op == sdt_pkg::OP_DEL_RANGE)
                       || (r_op == sdt_pkg::OP_DEL_BEFORE);
    assign w_is_list = (r_op == sdt_pkg::OP_LIST_RANGE);

    assign w_d_date = w_q[WW-1:PW];
    assign w_d_pay  = w_q[PW-1:0];
    assign w_in_rng = (w_d_date >= r_lo) && (w_d_date <= r_hi);

    // Inserts walk down from the top entry, all others walk up
    assign w_rd_avail = w_is_ins ? (r_rd != '0) : (r_rd < r_count);
    assign w_raddr    = w_is_ins ? AW'(r_rd - CW'(1)) : AW'(r_rd);
    assign w_didx_inc = CW'(r_didx) + CW'(1);

    assign w_out_free = !r_ov || i_m_tready;
    assign w_eval     = i_cmd.run && !r_imm && r_dv && !r_hit;
    assign w_mid      = w_eval && w_is_list && w_in_rng && r_pv;
    assign w_stall    = w_mid && !w_out_free;
    assign w_remove   = (r_op == sdt_pkg::OP_DEL_INDEX) ? (r_pos == sdt_pkg::POS_W'(r_didx))
                                                        : w_in_rng;

    always_comb begin
        w_hit_now = 1'b0;
        if (w_eval) begin
            if (w_is_ins) begin
                w_hit_now = (w_d_date < r_da);
            end else if (r_op == sdt_pkg::OP_FIND_DATE) begin
                w_hit_now = (w_d_date == r_da);
            end else if (r_op == sdt_pkg::OP_READ_INDEX) begin
                w_hit_now = 1'b1;
            end
        end
    end

    assign w_re = i_cmd.run && !r_imm && !r_hit && !w_hit_now && !w_stall && w_rd_avail;

    assign w_fin_fire = i_cmd.fin && w_out_free;

    assign o_stat.scan_end = r_imm || r_hit || (!w_rd_avail && !r_dv);
    assign o_stat.out_free = w_out_free;

    // Write port: shift, compact or place the new entry
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = w_q;
        if (w_eval && w_is_ins) begin
            w_we    = 1'b1;
            w_waddr = AW'(w_didx_inc);
            w_wdata = (w_d_date >= r_da) ? w_q : {r_da, r_pay};
        end else if (w_eval && w_is_pack && !w_remove) begin
            w_we    = 1'b1;
            w_waddr = AW'(r_wr);
        end else if (i_cmd.fin && w_is_ins && !r_imm && !r_hit) begin
            w_we    = 1'b1;
            w_waddr = '0;
            w_wdata = {r_da, r_pay};
        end
    end

    // Operand setup from the request
    always_comb begin
        n_lo  = (w_da < w_db) ? w_da : w_db;
        n_hi  = (w_da < w_db) ? w_db : w_da;
        n_imm = 1'b0;
        n_ist = sdt_pkg::ST_OK;
        n_rd  = '0;
        case (w_op)
            sdt_pkg::OP_INSERT: begin
                n_rd = r_count;
                if (r_count == CW'(CAPACITY)) begin
                    n_imm = 1'b1;
                    n_ist = sdt_pkg::ST_FULL;
                end
            end
            sdt_pkg::OP_READ_INDEX: begin
                n_rd = CW'(w_pos);
                if (w_pos >= r_count) begin
                    n_imm = 1'b1;
                    n_ist = sdt_pkg::ST_BAD_INDEX;
                end
            end
            sdt_pkg::OP_DEL_INDEX: begin
                if (w_pos >= r_count) begin
                    n_imm = 1'b1;
                    n_ist = sdt_pkg::ST_BAD_INDEX;
                end
            end
            sdt_pkg::OP_DEL_BEFORE: begin
                n_lo = '0;
                n_hi = w_da - DW'(1);
                if (w_da == '0) begin
                    n_imm = 1'b1;
                end
            end
            sdt_pkg::OP_FIND_DATE, sdt_pkg::OP_DEL_RANGE, sdt_pkg::OP_LIST_RANGE: begin
                n_imm = 1'b0;
            end
            default: begin
                n_imm = 1'b1;
                n_ist = sdt_pkg::ST_NO_MATCH;
            end
        endcase
    end

    // Closing result
    always_comb begin
        n_ost   = sdt_pkg::ST_OK;
        n_oidx  = '0;
        n_orem  = '0;
        n_odate = '0;
        n_opay  = '0;
        if (r_imm) begin
            n_ost = r_ist;
        end else if (w_is_ins) begin
            n_oidx = r_hit ? sdt_pkg::IDX_W'(r_ridx) : '0;
        end else if (w_is_pack) begin
            n_orem = sdt_pkg::REM_W'(r_rem);
        end else if (r_pv) begin
            n_oidx  = sdt_pkg::IDX_W'(r_pidx);
            n_odate = r_pdate;
            n_opay  = r_ppay;
        end else begin
            n_ost = sdt_pkg::ST_NO_MATCH;
        end
    end

    // Capture operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= w_op;
            r_da  <= w_da;
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_pos <= w_pos;
            r_pay <= w_pay;
            r_imm <= n_imm;
            r_ist <= n_ist;
        end
    end

    // Advance the walk pointers and counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd  <= n_rd;
            r_wr  <= '0;
            r_rem <= '0;
        end else begin
            if (w_re) begin
                r_rd   <= w_is_ins ? (r_rd - CW'(1)) : (r_rd + CW'(1));
                r_didx <= w_raddr;
            end
            if (w_eval && w_is_pack) begin
                if (w_remove) begin
                    r_rem <= r_rem + CW'(1);
                end else begin
                    r_wr <= r_wr + CW'(1);
                end
            end
            if (w_hit_now && w_is_ins) begin
                r_ridx <= AW'(w_didx_inc);
            end
        end
    end

    // Walk control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv  <= 1'b0;
            r_hit <= 1'b0;
        end else if (i_cmd.load) begin
            r_dv  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            if (!w_stall) begin
                r_dv <= w_re;
            end
            if (w_hit_now) begin
                r_hit <= 1'b1;
            end
        end
    end

    // Hold the pending entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_cmd.load) begin
            r_pv <= 1'b0;
        end else if ((w_hit_now && w_is_look) ||
                     (w_eval && w_is_list && w_in_rng && !w_stall)) begin
            r_pv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((w_hit_now && w_is_look) || (w_eval && w_is_list && w_in_rng && !w_stall)) begin
            r_pidx  <= r_didx;
            r_pdate <= w_d_date;
            r_ppay  <= w_d_pay;
        end
    end

    // Update the entry count when the request closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_fin_fire && !r_imm) begin
            if (w_is_ins) begin
                r_count <= r_count + CW'(1);
            end else if (w_is_pack) begin
                r_count <= r_wr;
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((w_mid && w_out_free) || w_fin_fire) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    // Output register payload: earlier listed entry or closing result
    always_ff @(posedge i_clk) begin
        if (w_mid && w_out_free) begin
            r_ost   <= sdt_pkg::ST_OK;
            r_oidx  <= sdt_pkg::IDX_W'(r_pidx);
            r_orem  <= '0;
            r_odate <= r_pdate;
            r_opay  <= r_ppay;
            r_olast <= 1'b0;
        end else if (w_fin_fire) begin
            r_ost   <= n_ost;
            r_oidx  <= n_oidx;
            r_orem  <= n_orem;
            r_odate <= n_odate;
            r_opay  <= n_opay;
            r_olast <= 1'b1;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {2'b00, r_opay, r_odate, r_orem, r_oidx, r_ost};
    assign o_m_tlast  = r_olast;

endmodule

/* sv/sdt_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdt_controller: request sequencer for the sorted date table
// Accepts a request when idle, runs the table walk until the datapath
// reports its end, then waits to deliver the closing result.
// ----------------------------------------------------------------------------
module sdt_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output sdt_pkg::t_ctrl_cmd o_cmd,
    input  sdt_pkg::t_dp_stat  i_stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign o_cmd.load = w_accept;
    assign o_cmd.run  = (r_state == S_RUN);
    assign o_cmd.fin  = (r_state == S_FIN);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_stat.scan_end) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/sorted_date_table.sv */
`timescale 1ns / 1ps
// Walk: inserts walk down the entries above the new one, finds stop at the
// first hit, deletes and lists walk all entry_count entries.
// Throughput: one request at a time, paced by the single RAM read port that
// reads one entry per cycle; a listed entry stalls while the output is held.
// Reset: synchronous, active low; empties the table, no clearing pass.
// ----------------------------------------------------------------------------
// sorted_date_table: date-sorted entry table with insert, lookup and deletes
// Keeps entries ordered by date key with a payload handle each, and answers
// insert, read, find, delete and list requests over streaming ports.
// ----------------------------------------------------------------------------
module sorted_date_table #(
    parameter int CAPACITY = sdt_pkg::CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // date_a, date_b, position, payload
    input  logic [2:0]  i_s_tuser,   // op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // status, result_index, removed_count,
                                     // entry_date, entry_payload
    output logic        o_m_tlast    // last
);

    sdt_pkg::t_ctrl_cmd w_cmd;
    sdt_pkg::t_dp_stat  w_stat;

    sdt_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    sdt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
